// ----- hdl/assert_macros.svh -----
// Assertion macros used by the grid dilation RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define GOD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define GOD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/god_pkg.sv -----
// Package with types and constants of the grid obstacle dilation core.
package god_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int MAX_RADIUS_DEF = 15;

    localparam logic [8:0]        RST_GRID_WIDTH  = 9'd256;
    localparam logic [8:0]        RST_GRID_HEIGHT = 9'd256;
    localparam logic [3:0]        RST_RADIUS      = 4'd10;
    localparam logic signed [7:0] RST_THRESHOLD   = 8'sd50;
    localparam logic signed [7:0] RST_FILL        = 8'sd100;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [2:0] {
        REG_GRID_WIDTH  = 3'd0,
        REG_GRID_HEIGHT = 3'd1,
        REG_RADIUS      = 3'd2,
        REG_THRESHOLD   = 3'd3,
        REG_FILL        = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [8:0]        grid_width;
        logic [8:0]        grid_height;
        logic [3:0]        window_radius;
        logic signed [7:0] obst_level;
        logic signed [7:0] fill_value;
    } god_cfg_t;

    typedef struct packed {
        logic              en;
        logic [7:0]        row;
        logic [7:0]        col;
        logic signed [7:0] data;
    } god_wr_t;

    typedef struct packed {
        logic       en;
        logic [8:0] row;
        logic [7:0] x0;
        logic [8:0] x1;
        logic [7:0] col;
    } god_rd_t;

    typedef struct packed {
        logic              hit;
        logic signed [7:0] center;
    } god_rsp_t;

endpackage

// ----- hdl/god_if.sv -----
// Valid/ready channel interfaces for input items and results.
interface god_in_if;
    logic              valid;
    logic              ready;
    logic              mode;
    logic [7:0]        column;
    logic [7:0]        row;
    logic signed [7:0] cell_value;

    modport source (output valid, mode, column, row, cell_value, input ready);
    modport sink (input valid, mode, column, row, cell_value, output ready);
endinterface

interface god_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] dilated_value;
    logic              status;

    modport source (output valid, dilated_value, status, input ready);
    modport sink (input valid, dilated_value, status, output ready);
endinterface

// ----- hdl/god_ram.sv -----
// Generic single-port RAM with registered read.
module god_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/god_cfg.sv -----
// APB configuration register file.
module god_cfg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output god_pkg::god_cfg_t cfg
);
    import god_pkg::*;

    god_cfg_t cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_width    <= RST_GRID_WIDTH;
            cfg_reg.grid_height   <= RST_GRID_HEIGHT;
            cfg_reg.window_radius <= RST_RADIUS;
            cfg_reg.obst_level    <= RST_THRESHOLD;
            cfg_reg.fill_value    <= RST_FILL;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_GRID_WIDTH:  cfg_reg.grid_width    <= pwdata[8:0];
                REG_GRID_HEIGHT: cfg_reg.grid_height   <= pwdata[8:0];
                REG_RADIUS:      cfg_reg.window_radius <= pwdata[3:0];
                REG_THRESHOLD:   cfg_reg.obst_level    <= pwdata[7:0];
                REG_FILL:        cfg_reg.fill_value    <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_GRID_WIDTH:  prdata = {23'd0, cfg_reg.grid_width};
            REG_GRID_HEIGHT: prdata = {23'd0, cfg_reg.grid_height};
            REG_RADIUS:      prdata = {28'd0, cfg_reg.window_radius};
            REG_THRESHOLD:   prdata = {24'd0, cfg_reg.obst_level};
            REG_FILL:        prdata = {24'd0, cfg_reg.fill_value};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

// ----- hdl/god_bank.sv -----
// Column-interleaved cell memory: one window row read per cycle, obstacle test per lane.
module god_bank #(
    parameter int MAX_WIDTH  = god_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = god_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_RADIUS = god_pkg::MAX_RADIUS_DEF
) (
    input  logic                clk,
    input  god_pkg::god_wr_t    wr,
    input  god_pkg::god_rd_t    rd,
    input  logic signed [7:0]   threshold,
    output god_pkg::god_rsp_t   rsp
);
    import god_pkg::*;

    localparam int LB     = $clog2(2 * MAX_RADIUS + 2);
    localparam int LANES  = 1 << LB;
    localparam int CPL    = (MAX_WIDTH + LANES - 1) / LANES;
    localparam int DEPTH  = MAX_HEIGHT * CPL;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]       lane_data [LANES];
    logic [LANES-1:0] lane_ok;
    logic [LANES-1:0] obst;
    logic [LANES-1:0] mask_reg;
    logic [LB-1:0]    center_lane_reg;

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic [LB-1:0]     off;
        logic [9:0]        lcol;
        logic [ADDR_W-1:0] raddr;
        logic [ADDR_W-1:0] waddr;
        logic              we;

        // column of the window that falls into this lane
        assign off   = LB'(l) - rd.x0[LB-1:0];
        assign lcol  = 10'(rd.x0) + 10'(off);
        assign lane_ok[l] = lcol <= 10'(rd.x1);
        assign raddr = ADDR_W'(32'(rd.row) * CPL + 32'(lcol >> LB));
        assign waddr = ADDR_W'(32'(wr.row) * CPL + 32'(wr.col >> LB));
        assign we    = wr.en && (wr.col[LB-1:0] == LB'(l));

        god_ram #(
            .WIDTH (8),
            .DEPTH (DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (we),
            .addr  (we ? waddr : raddr),
            .wdata (wr.data),
            .rdata (lane_data[l])
        );

        assign obst[l] = $signed(lane_data[l]) >= threshold;
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            mask_reg        <= lane_ok;
            center_lane_reg <= rd.col[LB-1:0];
        end
    end

    assign rsp.hit    = |(mask_reg & obst);
    assign rsp.center = lane_data[center_lane_reg];

endmodule

// ----- hdl/grid_obstacle_dilation_core.sv -----
// Top level of the grid obstacle dilation core.
// Loads give no result. An in-grid query reads its clipped window one row per cycle, all
// columns of a row at once from 2^ceil(log2(2*MAX_RADIUS+2)) column-interleaved lane
// memories, over at most 2r+1 window rows; a drain step then takes in the last row's
// response, and a finish step loads the result register, after which the next item is
// taken. A query outside the grid skips the scan and goes straight to the finish step.
// One item is in work at a time; an item may be accepted while a result still waits on the
// output, and a query then holds in its last step until the output is free. The cell
// memory is not cleared: every cell of the used grid must be loaded before queries.
`include "assert_macros.svh"

module grid_obstacle_dilation_core #(
    parameter int MAX_WIDTH  = god_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = god_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_RADIUS = god_pkg::MAX_RADIUS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    god_in_if.sink      item,
    god_out_if.source   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import god_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t   state_reg;
    god_cfg_t cfg;
    god_wr_t  wr;
    god_rd_t  rd;
    god_rsp_t rsp;

    logic [8:0]        w_eff;
    logic [8:0]        h_eff;
    logic [3:0]        r_eff;
    logic              on_grid;
    logic              accept;
    logic              accept_query;
    logic              out_load;
    logic [7:0]        x0_next;
    logic [8:0]        x1_next;
    logic [8:0]        y0_next;
    logic [8:0]        y1_next;

    logic [7:0]        x_reg;
    logic [8:0]        y_reg;
    logic [7:0]        x0_reg;
    logic [8:0]        x1_reg;
    logic [8:0]        y1_reg;
    logic [8:0]        cur_row_reg;
    logic              err_reg;
    logic              near_reg;
    logic signed [7:0] center_reg;
    logic              rsp_valid_reg;
    logic [8:0]        rsp_row_reg;
    logic              out_valid_reg;
    logic signed [7:0] out_value_reg;
    logic              out_status_reg;

    god_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    god_bank #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_bank (
        .clk       (clk),
        .wr        (wr),
        .rd        (rd),
        .threshold (cfg.obst_level),
        .rsp       (rsp)
    );

    assign w_eff = (32'(cfg.grid_width) > MAX_WIDTH) ? 9'(MAX_WIDTH) : cfg.grid_width;
    assign h_eff = (32'(cfg.grid_height) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : cfg.grid_height;
    assign r_eff = (32'(cfg.window_radius) > MAX_RADIUS) ? 4'(MAX_RADIUS)
                                                          : cfg.window_radius;

    assign on_grid = ({1'b0, item.column} < w_eff) && ({1'b0, item.row} < h_eff);

    // clipped window
    assign x0_next = (item.column >= 8'(r_eff)) ? item.column - 8'(r_eff) : 8'd0;
    assign x1_next = ({1'b0, item.column} + 9'(r_eff) < w_eff)
                   ? {1'b0, item.column} + 9'(r_eff) : w_eff - 9'd1;
    assign y0_next = (item.row >= 8'(r_eff)) ? 9'(item.row - 8'(r_eff)) : 9'd0;
    assign y1_next = ({1'b0, item.row} + 9'(r_eff) < h_eff)
                   ? {1'b0, item.row} + 9'(r_eff) : h_eff - 9'd1;

    assign item.ready   = (state_reg == ST_IDLE);
    assign accept       = item.valid && item.ready;
    assign accept_query = accept && (item.mode == MODE_QUERY);
    assign out_load     = (state_reg == ST_FINISH) && (!out_valid_reg || result.ready);

    assign wr.en   = accept && (item.mode == MODE_LOAD) && on_grid;
    assign wr.row  = item.row;
    assign wr.col  = item.column;
    assign wr.data = item.cell_value;

    assign rd.en  = (state_reg == ST_SCAN);
    assign rd.row = cur_row_reg;
    assign rd.x0  = x0_reg;
    assign rd.x1  = x1_reg;
    assign rd.col = x_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= 8'sd0;
            out_status_reg <= STATUS_OK;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rd.en;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.valid && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept_query)
                    begin
                        state_reg <= on_grid ? ST_SCAN : ST_FINISH;
                    end
                end
                ST_SCAN:
                begin
                    if (cur_row_reg == y1_reg)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (out_load)
                    begin
                        state_reg      <= ST_IDLE;
                        out_status_reg <= err_reg ? STATUS_ERR : STATUS_OK;
                        if (err_reg)
                        begin
                            out_value_reg <= 8'sd0;
                        end
                        else if (near_reg && (center_reg < cfg.obst_level))
                        begin
                            out_value_reg <= cfg.fill_value;
                        end
                        else
                        begin
                            out_value_reg <= center_reg;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_row_reg <= cur_row_reg;
        if (accept_query)
        begin
            x_reg       <= item.column;
            y_reg       <= {1'b0, item.row};
            x0_reg      <= x0_next;
            x1_reg      <= x1_next;
            y1_reg      <= y1_next;
            cur_row_reg <= y0_next;
            err_reg     <= !on_grid;
            near_reg    <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_SCAN)
            begin
                cur_row_reg <= cur_row_reg + 9'd1;
            end
            if (rsp_valid_reg)
            begin
                near_reg <= near_reg | rsp.hit;
                if (rsp_row_reg == y_reg)
                begin
                    center_reg <= rsp.center;
                end
            end
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.dilated_value = out_value_reg;
    assign result.status        = out_status_reg;

    `GOD_ASSERT_IMPLY(a_no_rd_on_wr, clk, rst_n, wr.en, !rd.en)
    `GOD_ASSERT_IMPLY(a_scan_in_window, clk, rst_n, state_reg == ST_SCAN, cur_row_reg <= y1_reg)
    `GOD_ASSERT_IMPLY(a_idle_no_rsp, clk, rst_n, state_reg == ST_IDLE, !rsp_valid_reg)
    `GOD_ASSERT_NEXT(a_finish_loads, clk, rst_n, out_load, out_valid_reg && state_reg == ST_IDLE)

endmodule

// ----- test/tb_top.sv -----
// Testbench for the grid obstacle dilation core: directed and random items checked by a predictor.
`timescale 1ns / 1ps

module tb_top;
    import god_pkg::*;

    localparam int         GRID_SPAN     = MAX_WIDTH_DEF;
    localparam int         GRID_CELLS    = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
    localparam int         CYCLE_LIMIT   = 600000;
    localparam int         SETTLE_CYCLES = 48;
    localparam logic [2:0] REG_SPARE     = 3'd5;

    typedef struct packed {
        logic signed [7:0] value;
        logic              status;
    } dilation_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    god_in_if  item_bus ();
    god_out_if result_bus ();

    grid_obstacle_dilation_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_bus),
        .result  (result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic signed [7:0] cell_mem [GRID_CELLS];
    bit                cell_loaded [GRID_CELLS];
    logic [8:0]        grid_cols = RST_GRID_WIDTH;
    logic [8:0]        grid_rows = RST_GRID_HEIGHT;
    logic [3:0]        radius    = RST_RADIUS;
    logic signed [7:0] threshold = RST_THRESHOLD;
    logic signed [7:0] fill      = RST_FILL;
    dilation_t         dilation_q [$];

    int fail_count    = 0;
    int useful_items  = 0;
    int cycle_count   = 0;
    int hold_cycles   = 0;
    int send_idle_pct = 20;
    int recv_idle_pct = 20;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int used_cols();
        return (grid_cols > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(grid_cols);
    endfunction

    function automatic int used_rows();
        return (grid_rows > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(grid_rows);
    endfunction

    function automatic int used_radius();
        return (radius > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : int'(radius);
    endfunction

    function automatic bit in_grid(int x, int y);
        return x < used_cols() && y < used_rows();
    endfunction

    function automatic int cell_addr(int x, int y);
        return y * GRID_SPAN + x;
    endfunction

    function automatic void window_bounds(input int x, input int y,
                                          output int x0, output int x1,
                                          output int y0, output int y1);
        int r;
        r  = used_radius();
        x0 = (x >= r) ? x - r : 0;
        y0 = (y >= r) ? y - r : 0;
        x1 = (x + r < used_cols()) ? x + r : used_cols() - 1;
        y1 = (y + r < used_rows()) ? y + r : used_rows() - 1;
    endfunction

    function automatic dilation_t dilate_cell(int x, int y);
        dilation_t         res;
        logic signed [7:0] centre;
        int                x0, x1, y0, y1;
        bit                hit;
        res.value  = '0;
        res.status = STATUS_ERR;
        hit        = 1'b0;
        if (in_grid(x, y))
        begin
            centre     = cell_mem[cell_addr(x, y)];
            res.status = STATUS_OK;
            res.value  = centre;
            if (centre < threshold)
            begin
                window_bounds(x, y, x0, x1, y0, y1);
                for (int yy = y0; yy <= y1; yy++)
                    for (int xx = x0; xx <= x1; xx++)
                        if (cell_mem[cell_addr(xx, yy)] >= threshold)
                            hit = 1'b1;
                if (hit)
                    res.value = fill;
            end
        end
        return res;
    endfunction

    // values cluster around the threshold and around zero, with some extremes, so that dilation decisions vary
    function automatic logic signed [7:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'($urandom);
            3:       return threshold;
            4:       return threshold - 8'sd1;
            5:       return -8'sd1;
            6:       return $urandom_range(0, 1) ? 8'sh7f : 8'sh80;
            default: return 8'($urandom_range(0, 8)) - 8'sd4;
        endcase
    endfunction

    task automatic send_item(input logic m, input logic [7:0] col, input logic [7:0] rw,
                             input logic signed [7:0] val);
        int cx;
        int cy;
        cx = int'(col);
        cy = int'(rw);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            item_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        item_bus.valid      <= 1'b1;
        item_bus.mode       <= m;
        item_bus.column     <= col;
        item_bus.row        <= rw;
        item_bus.cell_value <= val;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        if (m == MODE_QUERY)
        begin
            dilation_q.insert(dilation_q.size(), dilate_cell(cx, cy));
            useful_items++;
        end
        else if (in_grid(cx, cy))
        begin
            cell_mem[cell_addr(cx, cy)]    = val;
            cell_loaded[cell_addr(cx, cy)] = 1'b1;
            useful_items++;
        end
    endtask

    // a query never reaches a cell that was not loaded
    task automatic query_cell(input int x, input int y);
        int x0, x1, y0, y1;
        if (in_grid(x, y))
        begin
            window_bounds(x, y, x0, x1, y0, y1);
            for (int yy = y0; yy <= y1; yy++)
                for (int xx = x0; xx <= x1; xx++)
                    if (!cell_loaded[cell_addr(xx, yy)])
                        send_item(MODE_LOAD, 8'(xx), 8'(yy), pick_value());
        end
        send_item(MODE_QUERY, 8'(x), 8'(y), 8'($urandom));
    endtask

    task automatic settle();
        item_bus.valid <= 1'b0;
        while (dilation_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_GRID_WIDTH:  grid_cols = data[8:0];
            REG_GRID_HEIGHT: grid_rows = data[8:0];
            REG_RADIUS:      radius    = data[3:0];
            REG_THRESHOLD:   threshold = data[7:0];
            REG_FILL:        fill      = data[7:0];
            default:         ;
        endcase
    endtask

    task automatic set_config(input int cols, input int rows, input int rad, input int thr,
                              input int fil, input bit poke_spare);
        settle();
        write_reg(REG_GRID_WIDTH, 32'(cols));
        write_reg(REG_GRID_HEIGHT, 32'(rows));
        write_reg(REG_RADIUS, 32'(rad));
        write_reg(REG_THRESHOLD, 32'(thr));
        write_reg(REG_FILL, 32'(fil));
        if (poke_spare)
            write_reg(REG_SPARE, 32'hffff_ffff);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        query_cell(0, 0);
        query_cell(2, 1);
    endtask

    task automatic test_dilation_cases();
        logic signed [7:0] layout [12] = '{-8'sd1, 8'sd0, 8'sd0, 8'sd49,
                                           8'sd0, 8'sd0, 8'sd0, 8'sd0,
                                           8'sd0, -8'sd1, 8'sd0, 8'sd50};
        set_config(4, 3, 1, 50, 100, 1'b0);
        for (int i = 0; i < 12; i++)
            send_item(MODE_LOAD, 8'(i % 4), 8'(i / 4), layout[i]);
        send_item(MODE_LOAD, 8'd4, 8'd1, 8'sd99);
        query_cell(3, 2);
        query_cell(2, 1);
        query_cell(1, 2);
        query_cell(0, 0);
        query_cell(3, 0);
        query_cell(4, 1);
        query_cell(0, 3);
        query_cell(255, 255);
    endtask

    task automatic test_field_extremes();
        set_config(256, 256, 0, -128, 127, 1'b0);
        send_item(MODE_LOAD, 8'd0, 8'd0, 8'sh80);
        send_item(MODE_LOAD, 8'd255, 8'd0, 8'sh7f);
        send_item(MODE_LOAD, 8'd0, 8'd255, -8'sd1);
        send_item(MODE_LOAD, 8'd255, 8'd255, 8'sh55);
        query_cell(0, 0);
        query_cell(255, 0);
        query_cell(0, 255);
        query_cell(255, 255);
        set_config(256, 256, 1, 127, -128, 1'b0);
        query_cell(0, 0);
        query_cell(255, 0);
        query_cell(0, 255);
        query_cell(255, 255);
    endtask

    task automatic test_register_edges();
        set_config(0, 5, 3, 0, -1, 1'b0);
        send_item(MODE_LOAD, 8'd0, 8'd0, 8'sh12);
        query_cell(0, 0);
        query_cell(255, 4);
        set_config(511, 1, 15, 0, -1, 1'b0);
        query_cell(255, 0);
        query_cell(0, 0);
        query_cell(17, 1);
        set_config(1, 300, 15, 127, -128, 1'b0);
        query_cell(0, 255);
        query_cell(1, 0);
        set_config(1, 300, 15, 127, -128, 1'b1);
        query_cell(0, 240);
        query_cell(0, 3);
    endtask

    task automatic run_phase(input bit calm);
        bit wide_grid;
        bit off_grid;
        int cols, rows, rad, thr, fil;
        int ax, ay, x, y, k;
        wide_grid = ($urandom_range(0, 3) == 0);
        if (wide_grid)
        begin
            cols = ($urandom_range(0, 7) == 0) ? $urandom_range(257, 511) : $urandom_range(13, 256);
            rows = ($urandom_range(0, 7) == 0) ? $urandom_range(257, 511) : $urandom_range(1, 256);
            rad  = $urandom_range(0, 3);
        end
        else
        begin
            cols = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 12);
            rows = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 12);
            rad  = $urandom_range(0, 15);
        end
        case ($urandom_range(0, 5))
            0:       thr = -128;
            1:       thr = 127;
            2:       thr = int'($urandom_range(0, 255)) - 128;
            default: thr = int'($urandom_range(0, 12)) - 4;
        endcase
        if ($urandom_range(0, 4) == 0)
            fil = $urandom_range(0, 1) ? 127 : -128;
        else
            fil = int'($urandom_range(0, 255)) - 128;
        send_idle_pct = calm ? 0 : 10 * $urandom_range(0, 4);
        recv_idle_pct = calm ? 0 : 10 * $urandom_range(0, 4);
        set_config(cols, rows, rad, thr, fil, 1'b0);

        ax = (used_cols() > 0) ? $urandom_range(0, used_cols() - 1) : 0;
        ay = (used_rows() > 0) ? $urandom_range(0, used_rows() - 1) : 0;
        if ($urandom_range(0, 3) == 0)
            ax = $urandom_range(0, 1) ? 0 : used_cols() - 1;
        if ($urandom_range(0, 3) == 0)
            ay = $urandom_range(0, 1) ? 0 : used_rows() - 1;

        repeat ($urandom_range(30, 70))
        begin
            if (wide_grid)
            begin
                x = ax + int'($urandom_range(0, 4)) - 2;
                y = ay + int'($urandom_range(0, 4)) - 2;
            end
            else
            begin
                x = (used_cols() > 0) ? $urandom_range(0, used_cols() - 1) : 0;
                y = (used_rows() > 0) ? $urandom_range(0, used_rows() - 1) : 0;
            end
            if (x >= used_cols())
                x = used_cols() - 1;
            if (y >= used_rows())
                y = used_rows() - 1;
            if (x < 0)
                x = 0;
            if (y < 0)
                y = 0;

            k        = $urandom_range(0, 99);
            off_grid = (k >= 92) || used_cols() == 0 || used_rows() == 0;
            if (off_grid)
            begin
                if (used_cols() < MAX_WIDTH_DEF)
                begin
                    x = $urandom_range(used_cols(), 255);
                    y = $urandom_range(0, 255);
                end
                else if (used_rows() < MAX_HEIGHT_DEF)
                begin
                    x = $urandom_range(0, 255);
                    y = $urandom_range(used_rows(), 255);
                end
                else
                    off_grid = 1'b0;
            end

            if (off_grid && k % 2 == 0)
                send_item(MODE_LOAD, 8'(x), 8'(y), pick_value());
            else if (!off_grid && k < 35)
                send_item(MODE_LOAD, 8'(x), 8'(y), pick_value());
            else
                query_cell(x, y);
        end
    endtask

    task automatic test_random_phases();
        while (useful_items < 950)
            run_phase(1'b0);
    endtask

    // result side held off while queries keep coming, so the input backs up
    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(6, 6, 2, 1, 77, 1'b0);
        hold_cycles = 400;
        repeat (40)
            query_cell($urandom_range(0, 6), $urandom_range(0, 5));
    endtask

    task automatic test_sender_pause();
        send_idle_pct = 20;
        recv_idle_pct = 20;
        set_config(10, 8, 4, 0, -50, 1'b0);
        repeat (3)
        begin
            repeat (15)
                query_cell($urandom_range(0, 10), $urandom_range(0, 8));
            settle();
        end
    endtask

    task automatic test_streaming();
        repeat (3)
            run_phase(1'b1);
    endtask

    initial
    begin
        int stall_left;
        stall_left       = 0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                result_bus.ready <= 1'b0;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                result_bus.ready <= 1'b0;
                stall_left--;
            end
            else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct)
            begin
                result_bus.ready <= 1'b0;
                stall_left = $urandom_range(0, 6);
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        dilation_t want;
        if (result_bus.valid && result_bus.ready)
        begin
            if (dilation_q.size() == 0)
            begin
                $error("result transaction with nothing pending: dilated_value %0d status %0b",
                       result_bus.dilated_value, result_bus.status);
                fail_count++;
            end
            else
            begin
                want = dilation_q.pop_front();
                if (result_bus.dilated_value !== want.value)
                begin
                    $error("dilated_value mismatch: expected %0d, actual %0d",
                           $signed(want.value), result_bus.dilated_value);
                    fail_count++;
                end
                if (result_bus.status !== want.status)
                begin
                    $error("status mismatch: expected %0b, actual %0b",
                           want.status, result_bus.status);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        item_bus.valid      = 1'b0;
        item_bus.mode       = MODE_LOAD;
        item_bus.column     = '0;
        item_bus.row        = '0;
        item_bus.cell_value = '0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_dilation_cases();
        test_field_extremes();
        test_register_edges();
        test_random_phases();
        test_output_stall();
        test_sender_pause();
        test_streaming();
        settle();

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
